[rtl/ssag_pkg.sv]
`default_nettype none
package ssag_pkg;

   localparam int DIMENSIONS = 3;
   localparam int NUM_DIMS   = 3;
   localparam int CountW     = 32;
   localparam int WordW      = 64;
   localparam int CsrIndexW  = 4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_INNER_BYTES        = 4'd0,
      REG_COUNT_DIM0         = 4'd1,
      REG_COUNT_DIM1         = 4'd2,
      REG_COUNT_DIM2         = 4'd3,
      REG_STRIDE_DIM0        = 4'd4,
      REG_STRIDE_DIM1        = 4'd5,
      REG_STRIDE_DIM2        = 4'd6,
      REG_REQUIRED_ALIGNMENT = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      MUL_SEG01 = 3'd0,
      MUL_SEG   = 3'd1,
      MUL_PAY   = 3'd2,
      MUL_SPAN0 = 3'd3,
      MUL_SPAN1 = 3'd4,
      MUL_SPAN2 = 3'd5
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_SUM,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic        clear_chk;
      logic        mul_start;
      logic        mul_store;
      mul_sel_type mul_sel;
      logic        sum_step;
      logic [1:0]  step;
      logic        emit_fail;
      status_type  fail_status;
      logic        emit_first;
      logic        advance;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_bad;
      logic mul_done;
      logic ovf;
      logic first_last;
      logic adv_last;
      logic csr_hit;
   } dp_stat_type;

endpackage
`default_nettype wire

[rtl/strided_segment_address_generator.sv]
`default_nettype none
// Three-dimensional strided segment address generator. Write the descriptor through the
// csr_ port while idle, then send a word with req_restart=1: the descriptor is checked
// with one shared shift-add multiplier (six 64x64 products, one multiplier bit per cycle,
// each product started and stored by the controller) followed by three summing steps and one
// finishing step, after which the result of a restart (the first segment, or an error with
// status overflow) is valid; a zero size is caught at once and answered with status
// invalid in the next cycle. Each following word with req_restart=0 returns the next
// segment, one per cycle unless rsp_stall holds the response, until the segment with
// rsp_last_segment set; an advance without an active run gives no result.
module strided_segment_address_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_restart,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ssag_pkg::WordW-1:0]          rsp_address_delta,
   output logic [ssag_pkg::WordW-1:0]          rsp_payload_offset,
   output logic                               rsp_last_segment,
   output logic [1:0]                         rsp_status,
   output logic [ssag_pkg::WordW-1:0]          rsp_segment_count,
   output logic [ssag_pkg::WordW-1:0]          rsp_payload_bytes,
   output logic [ssag_pkg::WordW-1:0]          rsp_bounding_span,
   output logic                               rsp_non_overlapping,
   output logic                               rsp_alignment_ok,
   input  wire logic                          csr_write,
   input  wire logic [ssag_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [ssag_pkg::WordW-1:0]     csr_wdata
);
   import ssag_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ssag_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   ssag_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .address_delta   (rsp_address_delta),
      .payload_offset  (rsp_payload_offset),
      .last_segment    (rsp_last_segment),
      .status          (rsp_status),
      .segment_count   (rsp_segment_count),
      .payload_bytes   (rsp_payload_bytes),
      .bounding_span   (rsp_bounding_span),
      .non_overlapping (rsp_non_overlapping),
      .alignment_ok    (rsp_alignment_ok)
   );

endmodule
`default_nettype wire

[rtl/ssag_mul.sv]
`default_nettype none
module ssag_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ssag_pkg::WordW-1:0] op_a,
   input  wire logic [ssag_pkg::WordW-1:0] op_b,
   output logic                           done,
   output logic [ssag_pkg::WordW-1:0]     prod_lo,
   output logic                           ovf
);
   import ssag_pkg::*;

   // shift-add, one multiplier bit per cycle
   logic [WordW-1:0] mcand_ff, mcand_in;
   logic [WordW-1:0] hi_ff, hi_in;
   logic [WordW-1:0] lo_ff, lo_in;
   logic [$clog2(WordW)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [WordW:0] part;

   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      part     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         mcand_in = op_a;
         hi_in    = '0;
         lo_in    = op_b;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = part[WordW:1];
         lo_in  = {part[0], lo_ff[WordW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == $clog2(WordW)'(WordW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign prod_lo = lo_ff;
   assign ovf     = (hi_ff != '0);

endmodule
`default_nettype wire

[rtl/ssag_dp.sv]
`default_nettype none
module ssag_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [ssag_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [ssag_pkg::WordW-1:0]     csr_wdata,
   input  wire ssag_pkg::dp_cmd_type           cmd,
   output ssag_pkg::dp_stat_type               stat,
   output logic [ssag_pkg::WordW-1:0]          address_delta,
   output logic [ssag_pkg::WordW-1:0]          payload_offset,
   output logic                               last_segment,
   output logic [1:0]                         status,
   output logic [ssag_pkg::WordW-1:0]          segment_count,
   output logic [ssag_pkg::WordW-1:0]          payload_bytes,
   output logic [ssag_pkg::WordW-1:0]          bounding_span,
   output logic                               non_overlapping,
   output logic                               alignment_ok
);
   import ssag_pkg::*;

   // descriptor
   logic [WordW-1:0]  inner_ff, align_ff;
   logic [CountW-1:0] count_ff [NUM_DIMS];
   logic [WordW-1:0]  stride_ff [NUM_DIMS];
   logic [CountW-1:0] cnt_eff [NUM_DIMS];
   logic [WordW-1:0]  str_eff [NUM_DIMS];

   // check
   logic [WordW-1:0] seg01_ff, seg_ff, pay_ff, span_ff, covered_ff;
   logic [WordW-1:0] prod_ff [NUM_DIMS];
   logic ovf_ff, nonover_ff;
   logic [WordW-1:0] mul_a, mul_b, mul_p;
   logic mul_done, mul_ovf;
   logic [1:0] rank [NUM_DIMS];
   logic [1:0] order [NUM_DIMS];
   logic [1:0] od;
   logic [WordW:0] span_sum;
   logic aligned;

   // info and walk
   logic [WordW-1:0] info_seg_ff, info_pay_ff, info_span_ff;
   logic [1:0] info_flags_ff;
   logic [CountW-1:0] coord_ff [NUM_DIMS];
   logic [CountW-1:0] coord_in [NUM_DIMS];
   logic [WordW-1:0] row_ff, row_in, plane_ff, plane_in, addr_ff, addr_in, pos_ff;
   logic last_ff;
   status_type status_ff;
   logic [CountW:0] c0n, c1n;
   logic wrap0, wrap1;
   logic [CountW:0] lastchk [NUM_DIMS];

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         cnt_eff[d] = (d < DIMENSIONS) ? count_ff[d] : CountW'(1);
         str_eff[d] = (d < DIMENSIONS) ? stride_ff[d] : '0;
      end
   end

   assign stat.csr_hit  = csr_write && (csr_index <= REG_REQUIRED_ALIGNMENT);
   assign stat.zero_bad = (inner_ff == '0) || (cnt_eff[0] == '0) || (cnt_eff[1] == '0)
                          || (cnt_eff[2] == '0);
   assign stat.first_last = (cnt_eff[0] == CountW'(1)) && (cnt_eff[1] == CountW'(1))
                            && (cnt_eff[2] == CountW'(1));
   assign stat.mul_done = mul_done;
   assign stat.ovf      = ovf_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_SEG01: begin
            mul_a = WordW'(cnt_eff[0]);
            mul_b = WordW'(cnt_eff[1]);
         end
         MUL_SEG: begin
            mul_a = seg01_ff;
            mul_b = WordW'(cnt_eff[2]);
         end
         MUL_PAY: begin
            mul_a = seg_ff;
            mul_b = inner_ff;
         end
         MUL_SPAN0: begin
            mul_a = WordW'(cnt_eff[0] - 1'b1);
            mul_b = str_eff[0];
         end
         MUL_SPAN1: begin
            mul_a = WordW'(cnt_eff[1] - 1'b1);
            mul_b = str_eff[1];
         end
         MUL_SPAN2: begin
            mul_a = WordW'(cnt_eff[2] - 1'b1);
            mul_b = str_eff[2];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ssag_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .prod_lo (mul_p),
      .ovf     (mul_ovf)
   );

   // stride order, ties by dimension index
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         rank[d] = 2'd0;
         for (int e = 0; e < NUM_DIMS; e++) begin
            if (e != d && ((str_eff[e] < str_eff[d]) || (str_eff[e] == str_eff[d] && e < d)))
               rank[d] = rank[d] + 2'd1;
         end
      end
      for (int i = 0; i < NUM_DIMS; i++) begin
         order[i] = 2'd0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (rank[d] == 2'(i)) order[i] = 2'(d);
         end
      end
   end

   assign od       = order[cmd.step];
   assign span_sum = {1'b0, span_ff} + {1'b0, prod_ff[cmd.step]};

   always_comb begin
      aligned = (align_ff != '0) && ((align_ff & (align_ff - 1'b1)) == '0);
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (cnt_eff[d] > CountW'(1) && (str_eff[d] & (align_ff - 1'b1)) != '0)
            aligned = 1'b0;
      end
   end

   // segment walk: row and plane hold the start addresses of the current row and plane
   always_comb begin
      c0n = {1'b0, coord_ff[0]} + 1'b1;
      c1n = {1'b0, coord_ff[1]} + 1'b1;
      wrap0 = c0n >= {1'b0, cnt_eff[0]};
      wrap1 = c1n >= {1'b0, cnt_eff[1]};
      coord_in = coord_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      addr_in  = addr_ff;
      if (!wrap0) begin
         coord_in[0] = c0n[CountW-1:0];
         addr_in     = addr_ff + str_eff[0];
      end else if (!wrap1) begin
         coord_in[0] = '0;
         coord_in[1] = c1n[CountW-1:0];
         row_in      = row_ff + str_eff[1];
         addr_in     = row_in;
      end else begin
         coord_in[0] = '0;
         coord_in[1] = '0;
         coord_in[2] = coord_ff[2] + 1'b1;
         plane_in    = plane_ff + str_eff[2];
         row_in      = plane_in;
         addr_in     = plane_in;
      end
      for (int d = 0; d < NUM_DIMS; d++)
         lastchk[d] = {1'b0, coord_in[d]} + 1'b1;
   end

   assign stat.adv_last = (lastchk[0] >= {1'b0, cnt_eff[0]})
                          && (lastchk[1] >= {1'b0, cnt_eff[1]})
                          && (lastchk[2] >= {1'b0, cnt_eff[2]});

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff  <= WordW'(1);
         align_ff  <= WordW'(1);
         for (int d = 0; d < NUM_DIMS; d++) begin
            count_ff[d]  <= CountW'(1);
            stride_ff[d] <= '0;
            coord_ff[d]  <= '0;
         end
         info_seg_ff   <= '0;
         info_pay_ff   <= '0;
         info_span_ff  <= '0;
         info_flags_ff <= '0;
         row_ff    <= '0;
         plane_ff  <= '0;
         addr_ff   <= '0;
         pos_ff    <= '0;
         last_ff   <= 1'b0;
         status_ff <= STATUS_OK;
         ovf_ff    <= 1'b0;
         nonover_ff <= 1'b1;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_INNER_BYTES:        inner_ff     <= csr_wdata;
               REG_COUNT_DIM0:         count_ff[0]  <= csr_wdata[CountW-1:0];
               REG_COUNT_DIM1:         count_ff[1]  <= csr_wdata[CountW-1:0];
               REG_COUNT_DIM2:         count_ff[2]  <= csr_wdata[CountW-1:0];
               REG_STRIDE_DIM0:        stride_ff[0] <= csr_wdata;
               REG_STRIDE_DIM1:        stride_ff[1] <= csr_wdata;
               REG_STRIDE_DIM2:        stride_ff[2] <= csr_wdata;
               REG_REQUIRED_ALIGNMENT: align_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear_chk) begin
            ovf_ff     <= 1'b0;
            nonover_ff <= 1'b1;
            span_ff    <= inner_ff;
            covered_ff <= inner_ff;
         end
         if (cmd.mul_store) begin
            ovf_ff <= ovf_ff | mul_ovf;
            case (cmd.mul_sel)
               MUL_SEG01: seg01_ff   <= mul_p;
               MUL_SEG:   seg_ff     <= mul_p;
               MUL_PAY:   pay_ff     <= mul_p;
               MUL_SPAN0: prod_ff[0] <= mul_p;
               MUL_SPAN1: prod_ff[1] <= mul_p;
               MUL_SPAN2: prod_ff[2] <= mul_p;
               default: ;
            endcase
         end
         if (cmd.sum_step) begin
            span_ff <= span_sum[WordW-1:0];
            if (span_sum[WordW]) ovf_ff <= 1'b1;
            if (cnt_eff[od] != CountW'(1)) begin
               if (str_eff[od] < covered_ff) nonover_ff <= 1'b0;
               covered_ff <= covered_ff + prod_ff[od];
            end
         end
         if (cmd.emit_fail) begin
            info_seg_ff   <= '0;
            info_pay_ff   <= '0;
            info_span_ff  <= '0;
            info_flags_ff <= '0;
            addr_ff   <= '0;
            pos_ff    <= '0;
            last_ff   <= 1'b1;
            status_ff <= cmd.fail_status;
         end else if (cmd.emit_first) begin
            info_seg_ff   <= seg_ff;
            info_pay_ff   <= pay_ff;
            info_span_ff  <= span_ff;
            info_flags_ff <= {aligned, nonover_ff};
            for (int d = 0; d < NUM_DIMS; d++) coord_ff[d] <= '0;
            row_ff    <= '0;
            plane_ff  <= '0;
            addr_ff   <= '0;
            pos_ff    <= '0;
            last_ff   <= stat.first_last;
            status_ff <= STATUS_OK;
         end else if (cmd.advance) begin
            coord_ff  <= coord_in;
            row_ff    <= row_in;
            plane_ff  <= plane_in;
            addr_ff   <= addr_in;
            pos_ff    <= pos_ff + inner_ff;
            last_ff   <= stat.adv_last;
            status_ff <= STATUS_OK;
         end
      end
   end

   // these are the outputs of the check: seg01, seg, pay, span, covered, prod need no reset
   assign address_delta   = addr_ff;
   assign payload_offset  = pos_ff;
   assign last_segment    = last_ff;
   assign status          = status_ff;
   assign segment_count   = info_seg_ff;
   assign payload_bytes   = info_pay_ff;
   assign bounding_span   = info_span_ff;
   assign non_overlapping = info_flags_ff[0];
   assign alignment_ok    = info_flags_ff[1];

endmodule
`default_nettype wire

[rtl/ssag_ctrl.sv]
`default_nettype none
module ssag_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_restart,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire ssag_pkg::dp_stat_type stat,
   output ssag_pkg::dp_cmd_type       cmd
);
   import ssag_pkg::*;

   ctrl_state_type state_ff, state_in;
   mul_sel_type mul_sel_ff, mul_sel_in;
   logic [1:0] step_ff, step_in;
   logic run_ff, run_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mul_sel_in   = mul_sel_ff;
      step_in      = step_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = mul_sel_ff;
      cmd.step     = step_ff;
      cmd.fail_status = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  run_in = 1'b0;
                  if (stat.zero_bad) begin
                     cmd.emit_fail   = 1'b1;
                     cmd.fail_status = STATUS_INVALID;
                     rsp_valid_in    = 1'b1;
                  end else begin
                     cmd.clear_chk = 1'b1;
                     mul_sel_in    = MUL_SEG01;
                     state_in      = ST_MUL_GO;
                  end
               end else if (run_ff) begin
                  cmd.advance  = 1'b1;
                  rsp_valid_in = 1'b1;
                  run_in       = !stat.adv_last;
               end
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               cmd.mul_store = 1'b1;
               if (mul_sel_ff == MUL_SPAN2) begin
                  step_in  = 2'd0;
                  state_in = ST_SUM;
               end else begin
                  mul_sel_in = mul_sel_type'(mul_sel_ff + 3'd1);
                  state_in   = ST_MUL_GO;
               end
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            step_in      = step_ff + 2'd1;
            if (step_ff == 2'd2) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (stat.ovf) begin
               cmd.emit_fail   = 1'b1;
               cmd.fail_status = STATUS_OVERFLOW;
               run_in          = 1'b0;
            end else begin
               cmd.emit_first = 1'b1;
               run_in         = !stat.first_last;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // any descriptor write ends the run
      if (stat.csr_hit) run_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_sel_ff   <= MUL_SEG01;
         step_ff      <= 2'd0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_sel_ff   <= mul_sel_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("word accepted during descriptor check");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("check finished without a result");

   a_csr_ends_run: assert property (@(posedge clock) disable iff (reset)
      stat.csr_hit |=> !run_ff)
      else $error("run survived a descriptor write");

   a_check_no_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_GO || state_ff == ST_SUM) |-> !rsp_valid)
      else $error("result pending while checking");

endmodule
`default_nettype wire
